// ----- design/obef_pkg.sv -----
// Types, constants and saturation helpers for the oriented box extent fit block.
package obef_pkg;

   localparam int COMP_W = 32;
   localparam int PROJ_W = 36;
   localparam int OPA_W = 37;
   localparam int PROD_W = OPA_W + COMP_W;
   localparam int SUM_W = PROD_W + 2;
   localparam int FRAC_W = 16;
   localparam int SH_W = SUM_W - FRAC_W;
   localparam int PAD_W = 8;
   localparam int AXES = 3;

   localparam logic [PAD_W-1:0] PAD_RESET = 8'd1;

   localparam logic CMD_LOAD_AXIS = 1'b0;
   localparam logic CMD_ADD_POINT = 1'b1;

   localparam logic [1:0] AXIS_NONE = 2'd3;

   localparam logic [1:0] KIND_CENTER = 2'd0;
   localparam logic [1:0] KIND_SIDE_U = 2'd1;
   localparam logic [1:0] KIND_SIDE_V = 2'd2;
   localparam logic [1:0] KIND_SIDE_W = 2'd3;

   localparam logic [1:0] OP_PROJ = 2'd0;
   localparam logic [1:0] OP_CENTER = 2'd1;
   localparam logic [1:0] OP_SIDE = 2'd2;

   localparam logic signed [PROJ_W-1:0] PROJ_POS_MAX = {1'b0, {(PROJ_W-1){1'b1}}};
   localparam logic signed [PROJ_W-1:0] PROJ_NEG_MAX = {1'b1, {(PROJ_W-1){1'b0}}};

   typedef struct packed {
      logic command;
      logic [1:0] axis_select;
      logic signed [COMP_W-1:0] comp_x;
      logic signed [COMP_W-1:0] comp_y;
      logic signed [COMP_W-1:0] comp_z;
      logic final_point;
   } req_item_type;

   typedef struct packed {
      logic [1:0] vector_kind;
      logic signed [COMP_W-1:0] out_x;
      logic signed [COMP_W-1:0] out_y;
      logic signed [COMP_W-1:0] out_z;
      logic run_end;
   } rsp_item_type;

   typedef struct packed {
      logic valid;
      logic [1:0] op;
      logic [1:0] idx;
   } tag_type;

   function automatic logic signed [COMP_W-1:0] sat32(input logic signed [SH_W-1:0] v);
      logic fits;
      fits = (v[SH_W-1:COMP_W-1] == {(SH_W-COMP_W+1){v[SH_W-1]}});
      if (fits) begin
         return v[COMP_W-1:0];
      end else if (v[SH_W-1]) begin
         return {1'b1, {(COMP_W-1){1'b0}}};
      end else begin
         return {1'b0, {(COMP_W-1){1'b1}}};
      end
   endfunction

   function automatic logic signed [PROJ_W-1:0] sat36(input logic signed [SH_W-1:0] v);
      logic fits;
      fits = (v[SH_W-1:PROJ_W-1] == {(SH_W-PROJ_W+1){v[SH_W-1]}});
      if (fits) begin
         return v[PROJ_W-1:0];
      end else if (v[SH_W-1]) begin
         return PROJ_NEG_MAX;
      end else begin
         return PROJ_POS_MAX;
      end
   endfunction

endpackage

// ----- design/oriented_box_extent_fit.sv -----
// Oriented box fit along three stored axes: projection extremes, center and side vectors.
//
// Usage: an item is taken on a rising edge with start high and busy low. An axis-load
// item (command zero) writes axis u, v or w and leaves busy low; an axis select of three
// is ignored. A point item is projected onto the three axes by a shared three-multiplier
// dot unit, one axis per cycle; busy stays high until its last axis has been issued, so
// the next item is not taken before then. A point marked final also holds busy high
// through a wait for the last projection to reach the extremes, a step that forms
// midpoints and half extents, and the dot-unit operations for the three center
// components and the three side vectors. Its four results appear on rsp_strobe one per
// cycle: center, side u, side v, side w, run_end on the last. Each result is valid for
// exactly one cycle; the receiver cannot stall the block. The extremes are cleared once
// the final point's midpoints are formed; axes persist. The padding register is written
// through csr_we and csr_wdata; the user must write it only while the block is idle, as
// the block does not enforce this. Reset clears the axes to zero, the extremes to their
// empty values and sets padding to one.
module oriented_box_extent_fit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  obef_pkg::req_item_type               req_item,
   output logic                                 rsp_strobe,
   output obef_pkg::rsp_item_type               rsp_item,
   input  logic                                 csr_we,
   input  logic [obef_pkg::PAD_W-1:0]           csr_wdata
);
   import obef_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_PROJ = 3'd1;
   localparam logic [2:0] S_PWAIT = 3'd2;
   localparam logic [2:0] S_PREP = 3'd3;
   localparam logic [2:0] S_FIN = 3'd4;

   logic [2:0] state_ff, state_in;
   logic [2:0] step_ff, step_in;
   logic final_ff, final_in;
   logic [PAD_W-1:0] pad_ff;

   logic signed [COMP_W-1:0] point_ff [AXES];
   logic signed [COMP_W-1:0] axis_ff [AXES][AXES];
   logic signed [PROJ_W-1:0] min_ff [AXES];
   logic signed [PROJ_W-1:0] max_ff [AXES];
   logic signed [OPA_W-1:0] mid_ff [AXES];
   logic signed [OPA_W-1:0] mid_in [AXES];
   logic signed [OPA_W-1:0] half_ff [AXES];
   logic signed [OPA_W-1:0] half_in [AXES];
   logic signed [OPA_W-1:0] mid_sum [AXES];
   logic signed [OPA_W:0] half_sum [AXES];
   logic signed [COMP_W-1:0] center_ff [2];

   logic signed [COMP_W-1:0] req_comp [AXES];
   logic signed [OPA_W-1:0] opa [AXES];
   logic signed [COMP_W-1:0] opb [AXES];
   tag_type issue;
   logic [2:0] side_step;
   logic [1:0] side_idx;

   logic signed [PROD_W-1:0] prod_ff [AXES];
   logic signed [PROD_W-1:0] prod2_ff [AXES];
   logic signed [SUM_W-1:0] sum_ff;
   tag_type tag1_ff, tag2_ff;

   logic signed [SH_W-1:0] sum_sh;
   logic signed [PROJ_W-1:0] proj;
   logic signed [COMP_W-1:0] center_val;
   logic signed [COMP_W-1:0] side_val [AXES];

   logic rsp_strobe_ff, rsp_strobe_in;
   rsp_item_type rsp_item_ff, rsp_item_in;

   assign busy = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item = rsp_item_ff;

   assign req_comp[0] = req_item.comp_x;
   assign req_comp[1] = req_item.comp_y;
   assign req_comp[2] = req_item.comp_z;

   assign side_step = step_ff - 3'd3;
   assign side_idx = side_step[1:0];

   always_comb begin
      state_in = state_ff;
      step_in = step_ff;
      final_in = final_ff;
      issue = '0;
      for (int i = 0; i < AXES; i++) begin
         opa[i] = '0;
         opb[i] = '0;
      end
      unique case (state_ff)
         S_IDLE: begin
            if (start && req_item.command == CMD_ADD_POINT) begin
               issue.valid = 1'b1;
               issue.op = OP_PROJ;
               issue.idx = 2'd0;
               for (int i = 0; i < AXES; i++) begin
                  opa[i] = OPA_W'(req_comp[i]);
                  opb[i] = axis_ff[0][i];
               end
               final_in = req_item.final_point;
               step_in = 3'd1;
               state_in = S_PROJ;
            end
         end
         S_PROJ: begin
            issue.valid = 1'b1;
            issue.op = OP_PROJ;
            issue.idx = step_ff[1:0];
            for (int i = 0; i < AXES; i++) begin
               opa[i] = OPA_W'(point_ff[i]);
               opb[i] = axis_ff[step_ff[1:0]][i];
            end
            if (step_ff == 3'd2) begin
               step_in = 3'd0;
               state_in = final_ff ? S_PWAIT : S_IDLE;
            end else begin
               step_in = step_ff + 3'd1;
            end
         end
         S_PWAIT: begin
            if (step_ff == 3'd1) begin
               step_in = 3'd0;
               state_in = S_PREP;
            end else begin
               step_in = step_ff + 3'd1;
            end
         end
         S_PREP: begin
            step_in = 3'd0;
            state_in = S_FIN;
         end
         S_FIN: begin
            issue.valid = 1'b1;
            if (step_ff < 3'd3) begin
               issue.op = OP_CENTER;
               issue.idx = step_ff[1:0];
               for (int i = 0; i < AXES; i++) begin
                  opa[i] = mid_ff[i];
                  opb[i] = axis_ff[i][step_ff[1:0]];
               end
            end else begin
               issue.op = OP_SIDE;
               issue.idx = side_idx;
               for (int i = 0; i < AXES; i++) begin
                  opa[i] = half_ff[side_idx];
                  opb[i] = axis_ff[side_idx][i];
               end
            end
            if (step_ff == 3'd5) begin
               step_in = 3'd0;
               state_in = S_IDLE;
            end else begin
               step_in = step_ff + 3'd1;
            end
         end
         default: begin
            state_in = S_IDLE;
            step_in = 3'd0;
         end
      endcase
   end

   always_comb begin
      for (int a = 0; a < AXES; a++) begin
         mid_sum[a] = OPA_W'(max_ff[a]) + OPA_W'(min_ff[a]);
         mid_in[a] = mid_sum[a] >>> 1;
         half_sum[a] = (OPA_W+1)'(max_ff[a]) - (OPA_W+1)'(min_ff[a])
                       + $signed({{(OPA_W+1-PAD_W){1'b0}}, pad_ff});
         half_in[a] = OPA_W'(half_sum[a] >>> 1);
      end
   end

   always_comb begin
      sum_sh = sum_ff[SUM_W-1:FRAC_W];
      proj = sat36(sum_sh);
      center_val = sat32(sum_sh);
      for (int i = 0; i < AXES; i++) begin
         side_val[i] = sat32(SH_W'($signed(prod2_ff[i][PROD_W-1:FRAC_W])));
      end
      rsp_strobe_in = tag2_ff.valid
                      && ((tag2_ff.op == OP_CENTER && tag2_ff.idx == 2'd2)
                          || tag2_ff.op == OP_SIDE);
      if (tag2_ff.op == OP_CENTER) begin
         rsp_item_in.vector_kind = KIND_CENTER;
         rsp_item_in.out_x = center_ff[0];
         rsp_item_in.out_y = center_ff[1];
         rsp_item_in.out_z = center_val;
         rsp_item_in.run_end = 1'b0;
      end else begin
         rsp_item_in.vector_kind = tag2_ff.idx + 2'd1;
         rsp_item_in.out_x = side_val[0];
         rsp_item_in.out_y = side_val[1];
         rsp_item_in.out_z = side_val[2];
         rsp_item_in.run_end = (tag2_ff.idx == 2'd2);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff <= 3'd0;
         final_ff <= 1'b0;
         pad_ff <= PAD_RESET;
         tag1_ff <= '0;
         tag2_ff <= '0;
         rsp_strobe_ff <= 1'b0;
         for (int a = 0; a < AXES; a++) begin
            min_ff[a] <= PROJ_POS_MAX;
            max_ff[a] <= PROJ_NEG_MAX;
            for (int i = 0; i < AXES; i++) begin
               axis_ff[a][i] <= '0;
            end
         end
      end else begin
         state_ff <= state_in;
         step_ff <= step_in;
         final_ff <= final_in;
         tag1_ff <= issue;
         tag2_ff <= tag1_ff;
         rsp_strobe_ff <= rsp_strobe_in;
         if (csr_we) begin
            pad_ff <= csr_wdata;
         end
         if (state_ff == S_IDLE && start && req_item.command == CMD_LOAD_AXIS
             && req_item.axis_select != AXIS_NONE) begin
            for (int i = 0; i < AXES; i++) begin
               axis_ff[req_item.axis_select][i] <= req_comp[i];
            end
         end
         if (state_ff == S_PREP) begin
            for (int a = 0; a < AXES; a++) begin
               min_ff[a] <= PROJ_POS_MAX;
               max_ff[a] <= PROJ_NEG_MAX;
            end
         end else if (tag2_ff.valid && tag2_ff.op == OP_PROJ) begin
            if (proj < min_ff[tag2_ff.idx]) begin
               min_ff[tag2_ff.idx] <= proj;
            end
            if (proj > max_ff[tag2_ff.idx]) begin
               max_ff[tag2_ff.idx] <= proj;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && start) begin
         for (int i = 0; i < AXES; i++) begin
            point_ff[i] <= req_comp[i];
         end
      end
      if (state_ff == S_PREP) begin
         for (int a = 0; a < AXES; a++) begin
            mid_ff[a] <= mid_in[a];
            half_ff[a] <= half_in[a];
         end
      end
      for (int i = 0; i < AXES; i++) begin
         prod_ff[i] <= opa[i] * opb[i];
         prod2_ff[i] <= prod_ff[i];
      end
      sum_ff <= SUM_W'(prod_ff[0]) + SUM_W'(prod_ff[1]) + SUM_W'(prod_ff[2]);
      if (tag2_ff.valid && tag2_ff.op == OP_CENTER && tag2_ff.idx != 2'd2) begin
         center_ff[tag2_ff.idx[0]] <= center_val;
      end
      rsp_item_ff <= rsp_item_in;
   end

   a_run_end_last: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_item.run_end |-> rsp_item.vector_kind == KIND_SIDE_W)
      else $error("run_end set on a result other than side w");

   a_center_then_u: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_item.vector_kind == KIND_CENTER
      |=> rsp_strobe && rsp_item.vector_kind == KIND_SIDE_U)
      else $error("center result not followed by side u");

   a_extremes_cleared: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_PREP |=> min_ff[0] == PROJ_POS_MAX && max_ff[2] == PROJ_NEG_MAX)
      else $error("extremes not cleared after a final point");

   a_wait_only_final: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_PWAIT |-> final_ff)
      else $error("settle wait entered for a point that is not final");

   a_strobe_from_pipe: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(tag2_ff.valid) && $past(tag2_ff.op) != OP_PROJ)
      else $error("result strobe without a finished dot-unit operation");

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the oriented box extent fit block, with a scoreboard class.
module testbench;
   import obef_pkg::*;

   typedef logic signed [127:0] acc_type;

   localparam acc_type COMP_HI = 128'sd2147483647;
   localparam acc_type COMP_LO = -128'sd2147483648;
   localparam acc_type PROJ_HI = 128'sd34359738367;
   localparam acc_type PROJ_LO = -128'sd34359738368;
   localparam logic signed [COMP_W-1:0] CMAX = 32'h7fffffff;
   localparam logic signed [COMP_W-1:0] CMIN = 32'h80000000;
   localparam int STALL_LIMIT = 1000;
   localparam int SETTLE_CYCLES = 16;

   class box_extent_tracker;
      logic signed [COMP_W-1:0] axes [9];
      logic signed [PROJ_W-1:0] proj_lo [AXES];
      logic signed [PROJ_W-1:0] proj_hi [AXES];
      logic [PAD_W-1:0] padding;
      rsp_item_type pending_vectors [$];
      int unsigned mismatches;

      function new();
         foreach (axes[i]) axes[i] = '0;
         clear_extremes();
         padding = PAD_RESET;
         mismatches = 0;
      endfunction

      function void clear_extremes();
         foreach (proj_lo[a]) begin
            proj_lo[a] = PROJ_POS_MAX;
            proj_hi[a] = PROJ_NEG_MAX;
         end
      endfunction

      function logic signed [COMP_W-1:0] sat_comp(acc_type v);
         if (v > COMP_HI) begin
            return CMAX;
         end else if (v < COMP_LO) begin
            return CMIN;
         end
         return v[COMP_W-1:0];
      endfunction

      function void take_item(req_item_type it);
         acc_type pt [3];
         acc_type mid [AXES];
         acc_type half [AXES];
         acc_type sum;
         acc_type pad;
         logic signed [COMP_W-1:0] outv [3];
         logic [1:0] side_kind [AXES];
         rsp_item_type vec;
         side_kind[0] = KIND_SIDE_U;
         side_kind[1] = KIND_SIDE_V;
         side_kind[2] = KIND_SIDE_W;
         if (it.command == CMD_LOAD_AXIS) begin
            if (it.axis_select != AXIS_NONE) begin
               axes[3*it.axis_select] = it.comp_x;
               axes[3*it.axis_select+1] = it.comp_y;
               axes[3*it.axis_select+2] = it.comp_z;
            end
            return;
         end
         pt[0] = acc_type'(it.comp_x);
         pt[1] = acc_type'(it.comp_y);
         pt[2] = acc_type'(it.comp_z);
         for (int a = 0; a < AXES; a++) begin
            sum = 0;
            for (int j = 0; j < 3; j++) begin
               sum += pt[j] * axes[3*a+j];
            end
            sum = sum >>> FRAC_W;
            if (sum > PROJ_HI) begin
               sum = PROJ_HI;
            end else if (sum < PROJ_LO) begin
               sum = PROJ_LO;
            end
            if (sum < proj_lo[a]) begin
               proj_lo[a] = sum[PROJ_W-1:0];
            end
            if (sum > proj_hi[a]) begin
               proj_hi[a] = sum[PROJ_W-1:0];
            end
         end
         if (!it.final_point) begin
            return;
         end
         pad = acc_type'(padding);
         for (int a = 0; a < AXES; a++) begin
            mid[a] = (acc_type'(proj_hi[a]) + acc_type'(proj_lo[a])) >>> 1;
            half[a] = (acc_type'(proj_hi[a]) - acc_type'(proj_lo[a]) + pad) >>> 1;
         end
         for (int j = 0; j < 3; j++) begin
            sum = 0;
            for (int a = 0; a < AXES; a++) begin
               sum += mid[a] * axes[3*a+j];
            end
            outv[j] = sat_comp(sum >>> FRAC_W);
         end
         vec = '{KIND_CENTER, outv[0], outv[1], outv[2], 1'b0};
         pending_vectors.push_back(vec);
         for (int a = 0; a < AXES; a++) begin
            for (int j = 0; j < 3; j++) begin
               outv[j] = sat_comp((half[a] * axes[3*a+j]) >>> FRAC_W);
            end
            vec = '{side_kind[a], outv[0], outv[1], outv[2], a == 2};
            pending_vectors.push_back(vec);
         end
         clear_extremes();
      endfunction

      function void check_vector(rsp_item_type got);
         rsp_item_type want;
         if (pending_vectors.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected result, expected none, got kind %0d x %h y %h z %h end %b",
               $time, got.vector_kind, got.out_x, got.out_y, got.out_z, got.run_end);
            return;
         end
         want = pending_vectors.pop_front();
         if (got.vector_kind !== want.vector_kind || got.out_x !== want.out_x ||
               got.out_y !== want.out_y || got.out_z !== want.out_z ||
               got.run_end !== want.run_end) begin
            mismatches++;
            $display("%0t: result mismatch, expected kind %0d x %h y %h z %h end %b",
               $time, want.vector_kind, want.out_x, want.out_y, want.out_z, want.run_end);
            $display("%0t:                  got kind %0d x %h y %h z %h end %b",
               $time, got.vector_kind, got.out_x, got.out_y, got.out_z, got.run_end);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   req_item_type req_item = '0;
   logic rsp_strobe;
   rsp_item_type rsp_item;
   logic csr_we = 1'b0;
   logic [PAD_W-1:0] csr_wdata = '0;

   box_extent_tracker tracker = new();
   bit steady = 1'b0;
   int stall_cycles = 0;

   oriented_box_extent_fit i_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         tracker.check_vector(rsp_item);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((start && !busy) || rsp_strobe) begin
            stall_cycles = 0;
         end else begin
            stall_cycles++;
         end
         if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   function automatic req_item_type make_item(logic cmd, logic [1:0] sel,
         logic signed [COMP_W-1:0] x, logic signed [COMP_W-1:0] y,
         logic signed [COMP_W-1:0] z, logic fin);
      return '{cmd, sel, x, y, z, fin};
   endfunction

   // Styles: 0 full range, 1 within +-1.0, 2 within +-256.0, otherwise an extreme value.
   function automatic logic signed [COMP_W-1:0] rand_comp(int unsigned style);
      case (style)
         0: return $urandom();
         1: return int'($urandom_range(131072)) - 65536;
         2: return int'($urandom_range(33554432)) - 16777216;
         default: begin
            case ($urandom_range(4))
               0: return CMAX;
               1: return CMIN;
               2: return 0;
               3: return -1;
               default: return 1;
            endcase
         end
      endcase
   endfunction

   task automatic send_item(input req_item_type it);
      int gap;
      logic [127:0] junk;
      if (!steady && $urandom_range(99) < 37) begin
         gap = $urandom_range(4, 1);
         junk = {$urandom(), $urandom(), $urandom(), $urandom()};
         @(negedge clock);
         start = 1'b0;
         req_item = junk[$bits(req_item_type)-1:0];
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      start = 1'b1;
      req_item = it;
      forever begin
         @(posedge clock);
         if (!busy) break;
      end
      tracker.take_item(it);
   endtask

   task automatic drain();
      @(negedge clock);
      start = 1'b0;
      while (tracker.pending_vectors.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_padding(input logic [PAD_W-1:0] value);
      drain();
      @(negedge clock);
      csr_we = 1'b1;
      csr_wdata = value;
      @(negedge clock);
      csr_we = 1'b0;
      tracker.padding = value;
   endtask

   task automatic run_random(input int count);
      int sent;
      int roll;
      int pts;
      int unsigned style;
      logic [127:0] raw;
      sent = 0;
      while (sent < count) begin
         roll = $urandom_range(99);
         if (roll < 8) begin
            raw = {$urandom(), $urandom(), $urandom(), $urandom()};
            send_item(raw[$bits(req_item_type)-1:0]);
            sent++;
         end else if (roll < 30) begin
            roll = $urandom_range(99);
            style = roll < 60 ? 1 : (roll < 80 ? 2 : (roll < 92 ? 0 : 3));
            send_item(make_item(CMD_LOAD_AXIS, 2'($urandom_range(3)), rand_comp(style),
               rand_comp(style), rand_comp(style), 1'($urandom_range(1))));
            sent++;
         end else begin
            pts = $urandom_range(6, 1);
            roll = $urandom_range(99);
            style = roll < 55 ? 2 : (roll < 70 ? 1 : (roll < 88 ? 0 : 3));
            for (int k = 0; k < pts; k++) begin
               send_item(make_item(CMD_ADD_POINT, 2'($urandom_range(3)), rand_comp(style),
                  rand_comp(style), rand_comp(style), k == pts - 1));
            end
            sent += pts;
         end
      end
   endtask

   initial begin
      logic [PAD_W-1:0] pad_value;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // All axes are still zero after reset, so every vector collapses to the origin.
      send_item(make_item(CMD_ADD_POINT, 2'd0, CMAX, CMIN, CMAX, 1'b1));
      send_item(make_item(CMD_LOAD_AXIS, 2'd0, 32'sd65536, 32'sd0, 32'sd0, 1'b0));
      send_item(make_item(CMD_LOAD_AXIS, 2'd1, 32'sd0, 32'sd65536, 32'sd0, 1'b0));
      send_item(make_item(CMD_LOAD_AXIS, 2'd2, 32'sd0, 32'sd0, 32'sd65536, 1'b0));
      send_item(make_item(CMD_LOAD_AXIS, AXIS_NONE, CMIN, CMAX, CMIN, 1'b1));
      send_item(make_item(CMD_ADD_POINT, 2'd3, 32'sd0, 32'sd0, 32'sd0, 1'b0));
      send_item(make_item(CMD_ADD_POINT, 2'd1, CMAX, CMAX, CMAX, 1'b1));
      send_item(make_item(CMD_ADD_POINT, 2'd0, CMIN, CMIN, CMIN, 1'b1));
      send_item(make_item(CMD_ADD_POINT, 2'd0, 32'sd1, -32'sd1, 32'sd1, 1'b0));
      send_item(make_item(CMD_ADD_POINT, 2'd2, -32'sd1, 32'sd1, -32'sd1, 1'b1));
      send_item(make_item(CMD_LOAD_AXIS, 2'd0, CMAX, CMIN, CMAX, 1'b1));
      send_item(make_item(CMD_LOAD_AXIS, 2'd1, CMIN, CMIN, CMIN, 1'b0));
      send_item(make_item(CMD_LOAD_AXIS, 2'd2, CMAX, CMAX, CMAX, 1'b0));
      send_item(make_item(CMD_ADD_POINT, 2'd0, CMAX, CMIN, CMAX, 1'b0));
      send_item(make_item(CMD_ADD_POINT, 2'd0, CMIN, CMAX, CMIN, 1'b1));
      send_item(make_item(CMD_ADD_POINT, 2'd0, 32'sd0, 32'sd0, 32'sd0, 1'b1));
      send_item(make_item(CMD_LOAD_AXIS, 2'd0, -32'sd65536, 32'sd0, 32'sd0, 1'b1));
      send_item(make_item(CMD_ADD_POINT, 2'd0, 32'sd1, -32'sd1, 32'sd1, 1'b1));
      send_item(make_item(CMD_ADD_POINT, 2'd0, 32'sh00123456, -32'sh00654321, 32'sd7, 1'b1));

      for (int phase = 0; phase < 6; phase++) begin
         if (phase > 0) begin
            case (phase)
               1: pad_value = 8'd0;
               2: pad_value = 8'd255;
               3: pad_value = PAD_W'($urandom_range(254, 2));
               4: pad_value = 8'd1;
               default: pad_value = PAD_W'($urandom_range(255));
            endcase
            write_padding(pad_value);
         end
         steady = (phase == 3);
         run_random(74);
      end

      drain();
      if (tracker.mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ----- oriented_box_extent_fit.f -----
design/obef_pkg.sv
design/oriented_box_extent_fit.sv
tb/testbench.sv
